// ===== design/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types, codes and constants of the signal-to-MIDI modulator.
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

	localparam int RULES   = 4;
	localparam int NRULE   = (RULES < 4) ? RULES : 4;
	localparam int IDX_W   = (NRULE > 2) ? 2 : 1;
	localparam int CFG_W   = 26;
	localparam int CFGI_W  = 3;
	localparam int SIG_W   = 16;

	localparam logic [CFGI_W-1:0] CFG_RULE_COUNT = 3'd0;
	localparam logic [CFGI_W-1:0] CFG_RULE_BASE  = 3'd1;

	localparam logic [2:0]       RULE_COUNT_RST = 3'd1;
	localparam logic [CFG_W-1:0] RULE_WORD0_RST = 26'd8389200;

	localparam logic [2:0] TGT_VEL  = 3'd0;
	localparam logic [2:0] TGT_BEND = 3'd1;
	localparam logic [2:0] TGT_MOD  = 3'd2;
	localparam logic [2:0] TGT_AFT  = 3'd3;

	localparam logic [3:0] ST_NOTE_ON = 4'h9;
	localparam logic [3:0] ST_BEND    = 4'hE;
	localparam logic [3:0] ST_CTRL    = 4'hB;
	localparam logic [3:0] ST_AFT     = 4'hD;
	localparam logic [6:0] CC_MOD_WHEEL = 7'd1;

	typedef struct packed {
		logic [2:0]                  rule_count;
		logic [NRULE-1:0][CFG_W-1:0] rule_word;
	} cfg_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_MUL_SA,
		DP_MUL_QA,
		DP_MUL_BEND,
		DP_MUL_CC,
		DP_VF_ROUND,
		DP_MUL_VF,
		DP_PROD_UPD,
		DP_MUL_VEL
	} dp_op_t;

	typedef enum logic [1:0] {
		OUT_RULE,
		OUT_NOTE,
		OUT_PASS
	} out_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MUL2,
		S_EMIT,
		S_VSCAN,
		S_VRND,
		S_VMUL,
		S_VPROD,
		S_VFIN,
		S_VEMIT,
		S_PASS
	} state_t;

	typedef struct packed {
		dp_op_t           op;
		logic             load_in;
		logic             set_chan;
		logic             out_load;
		out_sel_t         out_sel;
		logic             last;
		logic [IDX_W-1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic is_midi;
		logic note_on;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== design/smm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// smm_cfg_regs
// Rule count and rule word registers behind the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [smm_pkg::CFGI_W-1:0]  cfg_index,
	input  wire logic [smm_pkg::CFG_W-1:0]   cfg_data,
	output smm_pkg::cfg_t                    cfg
);

	smm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rule_count <= smm_pkg::RULE_COUNT_RST;
			for (int i = 0; i < smm_pkg::NRULE; i++) begin
				cfg_q.rule_word[i] <= (i == 0) ? smm_pkg::RULE_WORD0_RST : '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == smm_pkg::CFG_RULE_COUNT) begin
				cfg_q.rule_count <= cfg_data[2:0];
			end
			for (int i = 0; i < smm_pkg::NRULE; i++) begin
				if (cfg_index == smm_pkg::CFG_RULE_BASE + smm_pkg::CFGI_W'(i)) begin
					cfg_q.rule_word[i] <= cfg_data;
				end
			end
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/smm_datapath.sv =====
// ----------------------------------------------------------------------------
// smm_datapath
// Input capture, shared 32x32 multiplier, rounding and clamping, channel
// register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  smm_pkg::cfg_t                   cfg,
	input  smm_pkg::dp_cmd_t                cmd,
	output smm_pkg::dp_stat_t               dp_stat,
	input  wire logic                       op,
	input  wire logic [7:0]                 status_in,
	input  wire logic [6:0]                 data_one_in,
	input  wire logic [6:0]                 data_two_in,
	input  wire logic [15:0]                offset_in,
	input  wire logic signed [15:0]         sig_zero,
	input  wire logic signed [15:0]         sig_one,
	input  wire logic signed [15:0]         sig_two,
	input  wire logic signed [15:0]         sig_three,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [7:0]                      status_out,
	output logic [6:0]                      data_one_out,
	output logic [6:0]                      data_two_out,
	output logic [15:0]                     offset_out,
	output logic                            last
);

	localparam logic signed [31:0] ONE28 = 32'sd268435456;
	localparam logic signed [31:0] ONE29 = 32'sd536870912;

	logic                    op_q;
	logic [7:0]              st_q;
	logic [6:0]              d1_q;
	logic [6:0]              d2_q;
	logic [15:0]             off_q;
	logic signed [15:0]      sig_in [4];
	logic signed [15:0]      sig_q  [smm_pkg::NRULE];
	logic [3:0]              chan_q;
	logic signed [63:0]      mul_q;
	logic signed [23:0]      f_q;
	logic signed [31:0]      prod_q;
	logic                    out_valid_q;

	logic signed [15:0]      sig_s;
	logic [smm_pkg::CFG_W-1:0] word;
	logic signed [15:0]      amt;
	logic [2:0]              tgt;
	logic [6:0]              cc;
	logic signed [31:0]      mx;
	logic signed [31:0]      my;
	logic signed [63:0]      mres;
	logic signed [31:0]      pl;
	logic signed [31:0]      bend_clamp;
	logic signed [31:0]      cc_clamp;
	logic signed [33:0]      f_full;
	logic signed [33:0]      f_rnd;
	logic signed [63:0]      rnd20;
	logic signed [43:0]      v_hi;
	logic [6:0]              vel;
	logic signed [63:0]      bend_t;
	logic [13:0]             bend;
	logic [37:0]             cc_t;
	logic [6:0]              ccv;
	logic                    out_free;

	assign sig_in[0] = sig_zero;
	assign sig_in[1] = sig_one;
	assign sig_in[2] = sig_two;
	assign sig_in[3] = sig_three;

	assign sig_s = sig_q[cmd.idx];
	assign word  = cfg.rule_word[cmd.idx];
	assign amt   = $signed(word[25:10]);
	assign tgt   = word[2:0];
	assign cc    = word[9:3];
	assign pl    = mul_q[31:0];

	always_comb begin
		if (pl > ONE28) begin
			bend_clamp = ONE28;
		end else if (pl < -ONE28) begin
			bend_clamp = -ONE28;
		end else begin
			bend_clamp = pl;
		end
		if (pl < 32'sd0) begin
			cc_clamp = 32'sd0;
		end else if (pl > ONE29) begin
			cc_clamp = ONE29;
		end else begin
			cc_clamp = pl;
		end
	end

	always_comb begin
		unique case (cmd.op)
			smm_pkg::DP_MUL_SA: begin
				mx = 32'(sig_s);
				my = 32'(amt);
			end
			smm_pkg::DP_MUL_QA: begin
				mx = {16'd0, ~sig_s[15], sig_s[14:0]};
				my = 32'(amt);
			end
			smm_pkg::DP_MUL_BEND: begin
				mx = bend_clamp;
				my = 32'sd8191;
			end
			smm_pkg::DP_MUL_CC: begin
				mx = cc_clamp;
				my = 32'sd127;
			end
			smm_pkg::DP_MUL_VF: begin
				mx = prod_q;
				my = 32'(f_q);
			end
			smm_pkg::DP_MUL_VEL: begin
				mx = {25'd0, d2_q};
				my = prod_q;
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	assign mres = mx * my;

	assign f_full = 34'(pl) + 34'sd268435456;
	assign f_rnd  = f_full + (f_full[33] ? 34'sd127 : 34'sd128);

	assign rnd20 = mul_q + (mul_q[63] ? 64'sd524287 : 64'sd524288);
	assign v_hi  = $signed(rnd20[63:20]);

	always_comb begin
		if (v_hi < 44'sd1) begin
			vel = 7'd1;
		end else if (v_hi > 44'sd127) begin
			vel = 7'd127;
		end else begin
			vel = v_hi[6:0];
		end
	end

	assign bend_t = mul_q + (mul_q[63] ? 64'sd134217727 : 64'sd134217728);
	assign bend   = 14'd8192 + bend_t[41:28];
	assign cc_t   = mul_q[37:0] + 38'd268435456;
	assign ccv    = cc_t[35:29];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= op;
			st_q  <= status_in;
			d1_q  <= data_one_in;
			d2_q  <= data_two_in;
			off_q <= offset_in;
			for (int i = 0; i < smm_pkg::NRULE; i++) begin
				sig_q[i] <= sig_in[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			smm_pkg::DP_MUL_SA, smm_pkg::DP_MUL_QA, smm_pkg::DP_MUL_BEND,
			smm_pkg::DP_MUL_CC, smm_pkg::DP_MUL_VF, smm_pkg::DP_MUL_VEL: begin
				mul_q <= mres;
			end
			smm_pkg::DP_VF_ROUND: begin
				f_q <= f_rnd[31:8];
			end
			smm_pkg::DP_PROD_UPD: begin
				prod_q <= rnd20[51:20];
			end
			default: begin
			end
		endcase
		if (cmd.load_in) begin
			prod_q <= 32'sd1048576;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
		end else if (cmd.set_chan) begin
			chan_q <= st_q[3:0];
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last <= cmd.last;
			unique case (cmd.out_sel)
				smm_pkg::OUT_RULE: begin
					offset_out <= '0;
					priority case (tgt)
						smm_pkg::TGT_BEND: begin
							status_out   <= {smm_pkg::ST_BEND, chan_q};
							data_one_out <= bend[6:0];
							data_two_out <= bend[13:7];
						end
						smm_pkg::TGT_MOD: begin
							status_out   <= {smm_pkg::ST_CTRL, chan_q};
							data_one_out <= smm_pkg::CC_MOD_WHEEL;
							data_two_out <= ccv;
						end
						smm_pkg::TGT_AFT: begin
							status_out   <= {smm_pkg::ST_AFT, chan_q};
							data_one_out <= ccv;
							data_two_out <= '0;
						end
						default: begin
							status_out   <= {smm_pkg::ST_CTRL, chan_q};
							data_one_out <= cc;
							data_two_out <= ccv;
						end
					endcase
				end
				smm_pkg::OUT_NOTE: begin
					status_out   <= st_q;
					data_one_out <= d1_q;
					data_two_out <= vel;
					offset_out   <= off_q;
				end
				default: begin
					status_out   <= st_q;
					data_one_out <= d1_q;
					data_two_out <= d2_q;
					offset_out   <= off_q;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign dp_stat.is_midi  = op_q;
	assign dp_stat.note_on  = (st_q[7:4] == smm_pkg::ST_NOTE_ON) && (d2_q != 7'd0);
	assign dp_stat.out_free = out_free;

endmodule

`default_nettype wire

// ===== design/smm_ctrl.sv =====
// ----------------------------------------------------------------------------
// smm_ctrl
// Sequencer: walks the rules for block starts and velocity scaling and
// drives the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  smm_pkg::cfg_t            cfg,
	input  smm_pkg::dp_stat_t        dp_stat,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output smm_pkg::dp_cmd_t         cmd
);

	smm_pkg::state_t                 state_q;
	smm_pkg::state_t                 state_d;
	logic [smm_pkg::IDX_W-1:0]       idx_q;
	logic [smm_pkg::IDX_W-1:0]       idx_d;
	logic [smm_pkg::NRULE-1:0]       emit;
	logic [smm_pkg::NRULE-1:0]       vmask;
	logic                            later;
	logic                            idx_end;
	logic [2:0]                      cur_tgt;

	always_comb begin
		for (int i = 0; i < smm_pkg::NRULE; i++) begin
			vmask[i] = (3'(i) < cfg.rule_count) &&
				(cfg.rule_word[i][2:0] == smm_pkg::TGT_VEL);
			emit[i]  = (3'(i) < cfg.rule_count) &&
				(cfg.rule_word[i][2:0] != smm_pkg::TGT_VEL) &&
				(cfg.rule_word[i][25:10] != 16'd0);
		end
		later = 1'b0;
		for (int j = 0; j < smm_pkg::NRULE; j++) begin
			if ((j > int'(idx_q)) && emit[j]) begin
				later = 1'b1;
			end
		end
	end

	assign idx_end = (idx_q == smm_pkg::IDX_W'(smm_pkg::NRULE - 1));
	assign cur_tgt = cfg.rule_word[idx_q][2:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smm_pkg::S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		in_ready     = 1'b0;
		cmd.op       = smm_pkg::DP_NOP;
		cmd.load_in  = 1'b0;
		cmd.set_chan = 1'b0;
		cmd.out_load = 1'b0;
		cmd.out_sel  = smm_pkg::OUT_RULE;
		cmd.last     = 1'b0;
		cmd.idx      = idx_q;
		unique case (state_q)
			smm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				idx_d    = '0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = smm_pkg::S_DECODE;
				end
			end
			smm_pkg::S_DECODE: begin
				priority if (!dp_stat.is_midi) begin
					state_d = smm_pkg::S_SCAN;
				end else if (dp_stat.note_on) begin
					cmd.set_chan = 1'b1;
					state_d      = smm_pkg::S_VSCAN;
				end else begin
					state_d = smm_pkg::S_PASS;
				end
			end
			smm_pkg::S_SCAN: begin
				priority if (emit == '0) begin
					state_d = smm_pkg::S_IDLE;
				end else if (emit[idx_q]) begin
					cmd.op  = (cur_tgt == smm_pkg::TGT_BEND) ?
						smm_pkg::DP_MUL_SA : smm_pkg::DP_MUL_QA;
					state_d = smm_pkg::S_MUL2;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			smm_pkg::S_MUL2: begin
				cmd.op  = (cur_tgt == smm_pkg::TGT_BEND) ?
					smm_pkg::DP_MUL_BEND : smm_pkg::DP_MUL_CC;
				state_d = smm_pkg::S_EMIT;
			end
			smm_pkg::S_EMIT: begin
				cmd.last = !later;
				if (dp_stat.out_free) begin
					cmd.out_load = 1'b1;
					if (later) begin
						idx_d   = idx_q + 1'b1;
						state_d = smm_pkg::S_SCAN;
					end else begin
						state_d = smm_pkg::S_IDLE;
					end
				end
			end
			smm_pkg::S_VSCAN: begin
				priority if (vmask[idx_q]) begin
					cmd.op  = smm_pkg::DP_MUL_SA;
					state_d = smm_pkg::S_VRND;
				end else if (idx_end) begin
					state_d = smm_pkg::S_VFIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			smm_pkg::S_VRND: begin
				cmd.op  = smm_pkg::DP_VF_ROUND;
				state_d = smm_pkg::S_VMUL;
			end
			smm_pkg::S_VMUL: begin
				cmd.op  = smm_pkg::DP_MUL_VF;
				state_d = smm_pkg::S_VPROD;
			end
			smm_pkg::S_VPROD: begin
				cmd.op = smm_pkg::DP_PROD_UPD;
				if (idx_end) begin
					state_d = smm_pkg::S_VFIN;
				end else begin
					idx_d   = idx_q + 1'b1;
					state_d = smm_pkg::S_VSCAN;
				end
			end
			smm_pkg::S_VFIN: begin
				cmd.op  = smm_pkg::DP_MUL_VEL;
				state_d = smm_pkg::S_VEMIT;
			end
			smm_pkg::S_VEMIT: begin
				cmd.out_sel = smm_pkg::OUT_NOTE;
				cmd.last    = 1'b1;
				if (dp_stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = smm_pkg::S_IDLE;
				end
			end
			smm_pkg::S_PASS: begin
				cmd.out_sel = smm_pkg::OUT_PASS;
				cmd.last    = 1'b1;
				if (dp_stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = smm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = smm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/signal_to_midi_modulator_unit.sv =====
// ----------------------------------------------------------------------------
// signal_to_midi_modulator_unit
// Maps up to four control signals onto MIDI messages per rule: pitch bend,
// mod wheel, aftertouch, CC, or note-on velocity scaling; else pass-through.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    op, status_in, data_one_in, data_two_in,
//                                   offset_in, sig_zero .. sig_three
//  out       out_valid / out_ready  status_out, data_one_out, data_two_out,
//                                   offset_out, last
//  cfg       cfg_we                 cfg_index, cfg_data
//
//  One item is worked on at a time, all products on the single shared
//  multiplier. Pass-through copies the item out; note-on walks all rule
//  slots, scaling velocity by each velocity rule; block start emits a message
//  per active non-velocity rule of nonzero amount. A stalled output holds
//  the sequencer; a new item is taken once the last result sits in the output
//  register. Reset clears config, sequencer, channel and output valid state.
// ----------------------------------------------------------------------------
`default_nettype none

module signal_to_midi_modulator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [smm_pkg::CFGI_W-1:0]  cfg_index,
	input  wire logic [smm_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        op,
	input  wire logic [7:0]                  status_in,
	input  wire logic [6:0]                  data_one_in,
	input  wire logic [6:0]                  data_two_in,
	input  wire logic [15:0]                 offset_in,
	input  wire logic signed [15:0]          sig_zero,
	input  wire logic signed [15:0]          sig_one,
	input  wire logic signed [15:0]          sig_two,
	input  wire logic signed [15:0]          sig_three,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [7:0]                       status_out,
	output logic [6:0]                       data_one_out,
	output logic [6:0]                       data_two_out,
	output logic [15:0]                      offset_out,
	output logic                             last
);

	smm_pkg::cfg_t     cfg;
	smm_pkg::dp_cmd_t  cmd;
	smm_pkg::dp_stat_t dp_stat;

	smm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.dp_stat  (dp_stat),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	smm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.dp_stat      (dp_stat),
		.op           (op),
		.status_in    (status_in),
		.data_one_in  (data_one_in),
		.data_two_in  (data_two_in),
		.offset_in    (offset_in),
		.sig_zero     (sig_zero),
		.sig_one      (sig_one),
		.sig_two      (sig_two),
		.sig_three    (sig_three),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status_out   (status_out),
		.data_one_out (data_one_out),
		.data_two_out (data_two_out),
		.offset_out   (offset_out),
		.last         (last)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while previous item still in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register overwritten before transfer");

	a_single_result_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && (cmd.out_sel != smm_pkg::OUT_RULE)) |-> cmd.last)
		else $error("MIDI item result not marked last");

endmodule

`default_nettype wire

// ===== tb/sv/signal_to_midi_modulator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signal_to_midi_modulator_unit_tb
// Drives block-start and MIDI items through the modulator under several rule
// settings. A bit-exact predictor works out the messages each item should
// produce. A monitor checks every result field against the oldest prediction.
// Both handshakes stall at random, and there are stretches with no stalls.
// ----------------------------------------------------------------------------

module signal_to_midi_modulator_unit_tb;
	import smm_pkg::*;

	localparam logic       OP_BLOCK      = 1'b0;
	localparam logic       OP_MIDI       = 1'b1;
	localparam logic [2:0] TGT_CC        = 3'd4;
	localparam int         SETTLE_CYCLES = 40;
	localparam longint     ONE_20        = longint'(1) << 20;
	localparam longint     ONE_28        = longint'(1) << 28;
	localparam longint     ONE_29        = longint'(1) << 29;

	typedef struct packed {
		logic            op;
		logic [7:0]      status;
		logic [6:0]      d_one;
		logic [6:0]      d_two;
		logic [15:0]     offset;
		logic [3:0][15:0] sig;
	} midi_item_t;

	typedef struct packed {
		logic [7:0]  status;
		logic [6:0]  d_one;
		logic [6:0]  d_two;
		logic [15:0] offset;
		logic        last;
	} midi_msg_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CFGI_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              out_valid;
	logic              out_ready = 1'b0;
	midi_item_t        cur = '0;
	logic              op;
	logic [7:0]        status_in;
	logic [6:0]        data_one_in;
	logic [6:0]        data_two_in;
	logic [15:0]       offset_in;
	logic signed [15:0] sig_zero;
	logic signed [15:0] sig_one;
	logic signed [15:0] sig_two;
	logic signed [15:0] sig_three;
	logic [7:0]        status_out;
	logic [6:0]        data_one_out;
	logic [6:0]        data_two_out;
	logic [15:0]       offset_out;
	logic              last;

	midi_item_t        pending_items [$];
	midi_msg_t         midi_expected [$];
	int                in_flight = 0;
	int                faults = 0;
	int                cycle_count = 0;
	logic              in_taken = 1'b0;
	logic              calm;

	logic [2:0]        rule_count_m;
	logic [CFG_W-1:0]  rule_words [NRULE];
	logic [3:0]        note_channel;

	assign op          = cur.op;
	assign status_in   = cur.status;
	assign data_one_in = cur.d_one;
	assign data_two_in = cur.d_two;
	assign offset_in   = cur.offset;
	assign sig_zero    = cur.sig[0];
	assign sig_one     = cur.sig[1];
	assign sig_two     = cur.sig[2];
	assign sig_three   = cur.sig[3];
	assign calm        = (cycle_count % 1500) < 300;

	signal_to_midi_modulator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.status_in    (status_in),
		.data_one_in  (data_one_in),
		.data_two_in  (data_two_in),
		.offset_in    (offset_in),
		.sig_zero     (sig_zero),
		.sig_one      (sig_one),
		.sig_two      (sig_two),
		.sig_three    (sig_three),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status_out   (status_out),
		.data_one_out (data_one_out),
		.data_two_out (data_two_out),
		.offset_out   (offset_out),
		.last         (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic report_fault(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		faults++;
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_fault($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	function automatic longint shift_round_away(longint x, int sh);
		longint mag;
		mag = (x < 0) ? -x : x;
		mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
		return (x < 0) ? -mag : mag;
	endfunction

	function automatic void predict_midi(midi_item_t it);
		longint    s, a, p, q, f, prod, v;
		int        n, i, first;
		logic [2:0] tgt;
		midi_msg_t m;
		first = midi_expected.size();
		n = (rule_count_m > NRULE) ? NRULE : rule_count_m;
		m = '0;
		if (it.op == OP_BLOCK) begin
			for (i = 0; i < n; i++) begin
				tgt = rule_words[i][2:0];
				a = longint'($signed(rule_words[i][25:10]));
				s = longint'($signed(it.sig[i]));
				if (tgt != TGT_VEL && a != 0) begin
					if (tgt == TGT_BEND) begin
						p = s * a;
						if (p > ONE_28) p = ONE_28;
						if (p < -ONE_28) p = -ONE_28;
						v = 8192 + shift_round_away(p * 8191, 28);
						if (v < 0) v = 0;
						if (v > 16383) v = 16383;
						m = '{{ST_BEND, note_channel}, v[6:0], v[13:7], 16'd0, 1'b0};
					end else begin
						q = (s + 32768) * a;
						if (q < 0) q = 0;
						if (q > ONE_29) q = ONE_29;
						v = (q * 127 + ONE_28) >>> 29;
						if (v > 127) v = 127;
						case (tgt)
							TGT_MOD: m = '{{ST_CTRL, note_channel}, CC_MOD_WHEEL, v[6:0], 16'd0, 1'b0};
							TGT_AFT: m = '{{ST_AFT, note_channel}, v[6:0], 7'd0, 16'd0, 1'b0};
							default: m = '{{ST_CTRL, note_channel}, rule_words[i][9:3], v[6:0],
								16'd0, 1'b0};
						endcase
					end
					midi_expected.insert(midi_expected.size(), m);
				end
			end
		end else if (it.status[7:4] == ST_NOTE_ON && it.d_two != 0) begin
			note_channel = it.status[3:0];
			prod = ONE_20;
			for (i = 0; i < n; i++) begin
				if (rule_words[i][2:0] == TGT_VEL) begin
					a = longint'($signed(rule_words[i][25:10]));
					s = longint'($signed(it.sig[i]));
					f = shift_round_away(ONE_28 + a * s, 8);
					prod = shift_round_away(prod * f, 20);
				end
			end
			v = shift_round_away(longint'(it.d_two) * prod, 20);
			if (v < 1) v = 1;
			if (v > 127) v = 127;
			m = '{it.status, it.d_one, v[6:0], it.offset, 1'b0};
			midi_expected.insert(midi_expected.size(), m);
		end else begin
			m = '{it.status, it.d_one, it.d_two, it.offset, 1'b0};
			midi_expected.insert(midi_expected.size(), m);
		end
		if (midi_expected.size() > first) begin
			m = midi_expected.pop_back();
			m.last = 1'b1;
			midi_expected.insert(midi_expected.size(), m);
		end
	endfunction

	// driver: hold each item until its transfer, then advance
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (arst_n && pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
				cur <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= calm || ($urandom_range(0, 99) >= 20);
	end

	always @(posedge clk) begin : monitor
		midi_msg_t want;
		cycle_count <= cycle_count + 1;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			predict_midi(cur);
			in_flight--;
		end
		if (arst_n && out_valid && out_ready) begin
			if (midi_expected.size() == 0) begin
				report_fault($sformatf("unexpected result, status %0h", status_out));
			end else begin
				want = midi_expected.pop_front();
				check_field("status", 16'(status_out), 16'(want.status));
				check_field("data one", 16'(data_one_out), 16'(want.d_one));
				check_field("data two", 16'(data_two_out), 16'(want.d_two));
				check_field("offset", offset_out, want.offset);
				check_field("last", 16'(last), 16'(want.last));
			end
		end
	end

	task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_RULE_COUNT)
			rule_count_m = data[2:0];
		else if (idx >= CFG_RULE_BASE && idx < CFG_RULE_BASE + NRULE)
			rule_words[idx - CFG_RULE_BASE] = data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_item(midi_item_t it);
		pending_items.insert(pending_items.size(), it);
		in_flight++;
	endtask

	task automatic settle();
		do @(negedge clk); while (in_flight != 0 || midi_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic midi_item_t make_item(logic o, logic [7:0] st, logic [6:0] d1,
			logic [6:0] d2, logic [15:0] off, logic [15:0] s0, logic [15:0] s1,
			logic [15:0] s2, logic [15:0] s3);
		midi_item_t it;
		it = '{o, st, d1, d2, off, {s3, s2, s1, s0}};
		return it;
	endfunction

	function automatic logic [15:0] rand_q16();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h2000;
			4: return 16'hE000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pack_rule(logic [2:0] tgt, logic [6:0] cc,
			logic [15:0] amount);
		return {amount, cc, tgt};
	endfunction

	function automatic midi_item_t rand_item();
		midi_item_t it;
		int i;
		it.op = ($urandom_range(0, 4) < 2) ? OP_BLOCK : OP_MIDI;
		it.status = ($urandom_range(0, 2) != 0) ? {ST_NOTE_ON, 4'($urandom)} : 8'($urandom);
		it.d_one = 7'($urandom);
		it.d_two = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom);
		it.offset = 16'($urandom);
		for (i = 0; i < 4; i++)
			it.sig[i] = rand_q16();
		return it;
	endfunction

	initial begin : stimulus
		int k, j;
		rule_count_m = RULE_COUNT_RST;
		rule_words[0] = RULE_WORD0_RST;
		for (j = 1; j < NRULE; j++)
			rule_words[j] = '0;
		note_channel = 4'd0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset rules: single velocity rule, amount one
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'h3}, 7'd60, 7'd127, 16'd0,
			16'h7FFF, 16'h0, 16'h0, 16'h0));
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'h5}, 7'd0, 7'd1, 16'd17,
			16'h8000, 16'h0, 16'h0, 16'h0));
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'h9}, 7'd127, 7'd0, 16'd5,
			16'h4000, 16'h0, 16'h0, 16'h0));
		queue_item(make_item(OP_MIDI, 8'h80, 7'd64, 7'd64, 16'd100,
			16'h0, 16'h0, 16'h0, 16'h0));
		queue_item(make_item(OP_MIDI, 8'h00, 7'h7F, 7'h7F, 16'hFFFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		queue_item(make_item(OP_BLOCK, 8'hFF, 7'h7F, 7'h7F, 16'hFFFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'hF}, 7'd10, 7'd64, 16'd1,
			16'h0, 16'h0, 16'h0, 16'h0));
		settle();

		// every emitting target, extreme amounts, target code above CC
		write_reg(CFG_RULE_COUNT, CFG_W'(4));
		write_reg(CFGI_W'(CFG_RULE_BASE + 0), pack_rule(TGT_BEND, 7'd0, 16'h7FFF));
		write_reg(CFGI_W'(CFG_RULE_BASE + 1), pack_rule(TGT_MOD, 7'd0, 16'h2000));
		write_reg(CFGI_W'(CFG_RULE_BASE + 2), pack_rule(TGT_AFT, 7'd0, 16'hE000));
		write_reg(CFGI_W'(CFG_RULE_BASE + 3), {CFG_W{1'b1}});
		queue_item(make_item(OP_BLOCK, 8'h0, 7'd0, 7'd0, 16'd0,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		queue_item(make_item(OP_BLOCK, 8'h0, 7'd0, 7'd0, 16'd0,
			16'h8000, 16'h8000, 16'h8000, 16'h8000));
		queue_item(make_item(OP_BLOCK, 8'h0, 7'd0, 7'd0, 16'd0, 16'h0, 16'h0, 16'h0, 16'h0));
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'hA}, 7'd33, 7'd100, 16'd9,
			16'h7FFF, 16'h8000, 16'h0, 16'h1234));
		queue_item(make_item(OP_BLOCK, 8'h0, 7'd0, 7'd0, 16'd0,
			16'h1234, 16'hC000, 16'h4000, 16'hFFFF));
		settle();

		// rule count above the limit, opposing velocity rules, unused indexes
		write_reg(CFG_RULE_COUNT, CFG_W'(7));
		write_reg(CFGI_W'(CFG_RULE_BASE + 0), pack_rule(TGT_VEL, 7'd0, 16'h8000));
		write_reg(CFGI_W'(CFG_RULE_BASE + 1), pack_rule(TGT_VEL, 7'd127, 16'h7FFF));
		write_reg(CFGI_W'(CFG_RULE_BASE + 2), pack_rule(TGT_CC, 7'd74, 16'h2000));
		write_reg(CFGI_W'(CFG_RULE_BASE + 3), pack_rule(TGT_MOD, 7'd0, 16'h0000));
		for (j = CFG_RULE_BASE + NRULE; j < 8; j++)
			write_reg(CFGI_W'(j), {CFG_W{1'b1}});
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'h1}, 7'd100, 7'd127, 16'd2,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'h2}, 7'd101, 7'd127, 16'd3,
			16'h8000, 16'h8000, 16'h8000, 16'h8000));
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'h6}, 7'd102, 7'd50, 16'd4,
			16'h2000, 16'hF000, 16'h0, 16'h0));
		queue_item(make_item(OP_BLOCK, 8'h0, 7'd0, 7'd0, 16'd0,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		queue_item(make_item(OP_BLOCK, 8'h0, 7'd0, 7'd0, 16'd0,
			16'h8000, 16'h8000, 16'h8000, 16'h8000));
		settle();

		// no active rules, then a velocity rule of zero amount
		write_reg(CFG_RULE_COUNT, CFG_W'(0));
		write_reg(CFGI_W'(CFG_RULE_BASE + 0), pack_rule(TGT_VEL, 7'd0, 16'h0000));
		queue_item(make_item(OP_BLOCK, 8'h0, 7'd0, 7'd0, 16'd0,
			16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'h4}, 7'd77, 7'd77, 16'd77,
			16'h7FFF, 16'h0, 16'h0, 16'h0));
		settle();
		write_reg(CFG_RULE_COUNT, CFG_W'(1));
		queue_item(make_item(OP_MIDI, {ST_NOTE_ON, 4'h4}, 7'd77, 7'd77, 16'd77,
			16'h8000, 16'h0, 16'h0, 16'h0));
		settle();

		for (k = 0; k < 10; k++) begin
			write_reg(CFG_RULE_COUNT, ($urandom_range(0, 2) == 0) ?
				CFG_W'($urandom_range(0, 7)) : CFG_W'(NRULE));
			for (j = 0; j < NRULE; j++)
				write_reg(CFGI_W'(CFG_RULE_BASE + j), pack_rule(
					($urandom_range(0, 3) == 0) ? TGT_VEL : 3'($urandom_range(0, 7)),
					7'($urandom), rand_q16()));
			if ($urandom_range(0, 1) == 1)
				write_reg(CFGI_W'($urandom_range(CFG_RULE_BASE + NRULE, 7)), CFG_W'($urandom));
			for (j = 0; j < 30; j++)
				queue_item(rand_item());
			settle();
		end

		if (midi_expected.size() != 0)
			report_fault($sformatf("%0d results never arrived", midi_expected.size()));
		if (faults == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/smm_pkg.sv
design/smm_cfg_regs.sv
design/smm_datapath.sv
design/smm_ctrl.sv
design/signal_to_midi_modulator_unit.sv
tb/sv/signal_to_midi_modulator_unit_tb.sv
